// ===== hdl/ilv_pkg.sv =====
package ilv_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_FAIL   = 3'd4
  } phase_e;

  localparam int unsigned BaseW = 6;
  localparam int unsigned CharW = 8;

  localparam logic [BaseW-1:0] BaseReset = 6'd10;
  localparam logic [BaseW-1:0] BaseDec   = 6'd10;
  localparam logic [BaseW-1:0] BaseOct   = 6'd8;
  localparam logic [BaseW-1:0] BaseHex   = 6'd16;
  localparam logic [BaseW-1:0] BaseBin   = 6'd2;

  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowZ   = 8'h7a;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpZ    = 8'h5a;
  localparam logic [CharW-1:0] ChMinus  = 8'h2d;
  localparam logic [CharW-1:0] ChLowX   = 8'h78;
  localparam logic [CharW-1:0] ChUpX    = 8'h58;
  localparam logic [CharW-1:0] ChLowB   = 8'h62;
  localparam logic [CharW-1:0] ChUpB    = 8'h42;

  typedef struct packed {
    phase_e           phase;
    logic [BaseW-1:0] base;
    logic             end_ok;
  } parse_state_t;

  // True when the character is a letter or digit whose value is below base.
  function automatic logic digit_ok(input logic [CharW-1:0] c, input logic [BaseW-1:0] base);
    logic [CharW-1:0] v;
    logic             is_digit;
    v        = '0;
    is_digit = 1'b0;
    if (c >= ChZero && c <= ChNine) begin
      v        = c - ChZero;
      is_digit = 1'b1;
    end else if (c >= ChLowA && c <= ChLowZ) begin
      v        = c - ChLowA + 8'd10;
      is_digit = 1'b1;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      v        = c - ChUpA + 8'd10;
      is_digit = 1'b1;
    end
    return is_digit && (v < {2'b00, base});
  endfunction

endpackage

// ===== hdl/ilv_step.sv =====
module ilv_step (
  input  logic [ilv_pkg::CharW-1:0] char_code_i,
  input  logic                      is_last_i,
  input  logic                      empty_string_i,
  input  logic [ilv_pkg::BaseW-1:0] number_base_i,
  input  ilv_pkg::parse_state_t     state_i,
  output ilv_pkg::parse_state_t     state_o,
  output logic                      emit_o,
  output logic                      is_valid_o
);

  ilv_pkg::parse_state_t nxt;
  ilv_pkg::parse_state_t start_st;

  assign start_st = '{phase: ilv_pkg::PH_START, base: '0, end_ok: 1'b0};

  always_comb begin
    nxt = state_i;
    case (state_i.phase)
      ilv_pkg::PH_START, ilv_pkg::PH_SIGN: begin
        if (state_i.phase == ilv_pkg::PH_START && char_code_i == ilv_pkg::ChMinus) begin
          nxt.phase  = ilv_pkg::PH_SIGN;
          nxt.end_ok = 1'b0;
        end else if (number_base_i != '0) begin
          nxt.base   = number_base_i;
          nxt.end_ok = ilv_pkg::digit_ok(char_code_i, number_base_i);
          nxt.phase  = nxt.end_ok ? ilv_pkg::PH_DIGITS : ilv_pkg::PH_FAIL;
        end else if (char_code_i == ilv_pkg::ChZero) begin
          nxt.base   = ilv_pkg::BaseOct;
          nxt.phase  = ilv_pkg::PH_ZERO;
          nxt.end_ok = 1'b1;
        end else begin
          nxt.base   = ilv_pkg::BaseDec;
          nxt.end_ok = ilv_pkg::digit_ok(char_code_i, ilv_pkg::BaseDec);
          nxt.phase  = nxt.end_ok ? ilv_pkg::PH_DIGITS : ilv_pkg::PH_FAIL;
        end
      end
      ilv_pkg::PH_ZERO: begin
        if (char_code_i == ilv_pkg::ChLowX || char_code_i == ilv_pkg::ChUpX) begin
          nxt.base   = ilv_pkg::BaseHex;
          nxt.phase  = ilv_pkg::PH_DIGITS;
          nxt.end_ok = 1'b0;
        end else if (char_code_i == ilv_pkg::ChLowB || char_code_i == ilv_pkg::ChUpB) begin
          nxt.base   = ilv_pkg::BaseBin;
          nxt.phase  = ilv_pkg::PH_DIGITS;
          nxt.end_ok = 1'b0;
        end else begin
          nxt.base   = ilv_pkg::BaseOct;
          nxt.end_ok = ilv_pkg::digit_ok(char_code_i, ilv_pkg::BaseOct);
          nxt.phase  = nxt.end_ok ? ilv_pkg::PH_DIGITS : ilv_pkg::PH_FAIL;
        end
      end
      ilv_pkg::PH_DIGITS: begin
        nxt.end_ok = ilv_pkg::digit_ok(char_code_i, state_i.base);
        nxt.phase  = nxt.end_ok ? ilv_pkg::PH_DIGITS : ilv_pkg::PH_FAIL;
      end
      default: begin
        nxt.phase  = ilv_pkg::PH_FAIL;
        nxt.end_ok = 1'b0;
      end
    endcase
  end

  // An empty string abandons whatever was parsed so far.
  assign emit_o     = empty_string_i | is_last_i;
  assign is_valid_o = !empty_string_i && nxt.phase != ilv_pkg::PH_FAIL && nxt.end_ok;
  assign state_o    = emit_o ? start_st : nxt;

endmodule

// ===== hdl/integer_literal_validator.sv =====
// Streaming integer literal checker. Characters arrive one request at a time
// on the input channel (char_code_i, is_last_i, empty_string_i with
// in_valid_i/in_ready_o). When a request ends a string (is_last_i or
// empty_string_i set), one verdict leaves on the output channel as is_valid_o
// with out_valid_o/out_ready_o; other characters produce no output.
// The user writes number_base_i with number_base_we_i only while no string
// is in flight; the block itself does not enforce this. 0 infers the base
// from a 0x, 0b or 0 prefix, other values fix it. Each request is registered
// in the input register, then the parse logic feeds the output register. The
// parse state update is a single short combinational step; throughput is one
// character per cycle unless an ending request waits for the output register.
// When the receiver stalls, the verdict holds in the output register and the
// input register still drains characters that produce no verdict; a request
// that ends a string waits in the input register until the output register
// is free, and in_ready_o stays low meanwhile. Reset empties both registers,
// returns the parser to the start of a string and sets the base to 10.
module integer_literal_validator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      number_base_we_i,
  input  logic [ilv_pkg::BaseW-1:0] number_base_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ilv_pkg::CharW-1:0] char_code_i,
  input  logic                      is_last_i,
  input  logic                      empty_string_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      is_valid_o
);

  logic [ilv_pkg::BaseW-1:0] base_q;
  logic                      in_vld_q;
  logic [ilv_pkg::CharW-1:0] char_q;
  logic                      last_q;
  logic                      empty_q;
  ilv_pkg::parse_state_t     st_q;
  ilv_pkg::parse_state_t     st_d;
  logic                      out_vld_q;
  logic                      res_q;
  logic                      res_d;
  logic                      emit;
  logic                      out_free;
  logic                      adv;

  ilv_step u_step (
    .char_code_i    (char_q),
    .is_last_i      (last_q),
    .empty_string_i (empty_q),
    .number_base_i  (base_q),
    .state_i        (st_q),
    .state_o        (st_d),
    .emit_o         (emit),
    .is_valid_o     (res_d)
  );

  assign out_free   = !out_vld_q || out_ready_i;
  assign adv        = in_vld_q && (out_free || !emit);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= ilv_pkg::BaseReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: ilv_pkg::PH_START, base: '0, end_ok: 1'b0};
    end else begin
      if (number_base_we_i) begin
        base_q <= number_base_i;
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        st_q <= st_d;
      end
      if (adv && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q  <= char_code_i;
      last_q  <= is_last_i;
      empty_q <= empty_string_i;
    end
    if (adv && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign is_valid_o  = res_q;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CharW      = ilv_pkg::CharW;
  localparam int unsigned BaseW      = ilv_pkg::BaseW;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 120;

  // Mirrors the parser: it follows every accepted request and queues the
  // verdict each finished string should produce.
  class literal_scoreboard;
    logic [BaseW-1:0] number_base;
    ilv_pkg::phase_e  phase;
    logic [BaseW-1:0] active_base;
    logic             end_ok;
    logic             verdict_q[$];
    int unsigned      mismatches;

    function new();
      number_base = ilv_pkg::BaseReset;
      mismatches  = 0;
      restart();
    endfunction

    function void restart();
      phase       = ilv_pkg::PH_START;
      active_base = '0;
      end_ok      = 1'b0;
    endfunction

    function void set_base(input logic [BaseW-1:0] b);
      number_base = b;
    endfunction

    function bit value_below_base(input logic [CharW-1:0] c,
                                  input logic [BaseW-1:0] b);
      int v;
      if (c >= ilv_pkg::ChZero && c <= ilv_pkg::ChNine) begin
        v = c - ilv_pkg::ChZero;
      end else if (c >= ilv_pkg::ChLowA && c <= ilv_pkg::ChLowZ) begin
        v = c - ilv_pkg::ChLowA + 10;
      end else if (c >= ilv_pkg::ChUpA && c <= ilv_pkg::ChUpZ) begin
        v = c - ilv_pkg::ChUpA + 10;
      end else begin
        return 1'b0;
      end
      return v < b;
    endfunction

    function void take_digit(input logic [CharW-1:0] c);
      if (value_below_base(c, active_base)) begin
        phase  = ilv_pkg::PH_DIGITS;
        end_ok = 1'b1;
      end else begin
        phase  = ilv_pkg::PH_FAIL;
        end_ok = 1'b0;
      end
    endfunction

    // First character after an optional sign fixes or infers the base.
    function void open_magnitude(input logic [CharW-1:0] c);
      if (number_base != 0) begin
        active_base = number_base;
        take_digit(c);
      end else if (c == ilv_pkg::ChZero) begin
        active_base = ilv_pkg::BaseOct;
        phase       = ilv_pkg::PH_ZERO;
        end_ok      = 1'b1;
      end else begin
        active_base = ilv_pkg::BaseDec;
        take_digit(c);
      end
    endfunction

    function void note_request(input logic [CharW-1:0] c, input logic last,
                               input logic empty);
      if (empty) begin
        verdict_q.push_back(1'b0);
        restart();
        return;
      end
      case (phase)
        ilv_pkg::PH_START: begin
          if (c == ilv_pkg::ChMinus) begin
            phase  = ilv_pkg::PH_SIGN;
            end_ok = 1'b0;
          end else begin
            open_magnitude(c);
          end
        end
        ilv_pkg::PH_SIGN: open_magnitude(c);
        ilv_pkg::PH_ZERO: begin
          if (c == ilv_pkg::ChLowX || c == ilv_pkg::ChUpX) begin
            active_base = ilv_pkg::BaseHex;
            phase       = ilv_pkg::PH_DIGITS;
            end_ok      = 1'b0;
          end else if (c == ilv_pkg::ChLowB || c == ilv_pkg::ChUpB) begin
            active_base = ilv_pkg::BaseBin;
            phase       = ilv_pkg::PH_DIGITS;
            end_ok      = 1'b0;
          end else begin
            active_base = ilv_pkg::BaseOct;
            take_digit(c);
          end
        end
        ilv_pkg::PH_DIGITS: take_digit(c);
        default: begin
          phase  = ilv_pkg::PH_FAIL;
          end_ok = 1'b0;
        end
      endcase
      if (last) begin
        verdict_q.push_back(phase != ilv_pkg::PH_FAIL && end_ok);
        restart();
      end
    endfunction

    function void check_verdict(input logic got);
      logic want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected verdict %0b with nothing pending", got);
        end
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("verdict mismatch: expected %0b, got %0b", want, got);
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             number_base_we_i = 1'b0;
  logic [BaseW-1:0] number_base_i = ilv_pkg::BaseReset;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [CharW-1:0] char_code_i = '0;
  logic             is_last_i = 1'b0;
  logic             empty_string_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             is_valid_o;

  literal_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned sent       = 0;
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  int unsigned hold_asks  = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;
  int unsigned rx_count   = 0;
  int unsigned rx_mode    = 0;

  integer_literal_validator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .number_base_we_i(number_base_we_i),
    .number_base_i   (number_base_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .is_last_i       (is_last_i),
    .empty_string_i  (empty_string_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_valid_o      (is_valid_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver: takes verdicts and stalls on its own pattern, with a long
  // hold-off whenever the stimulus asks for one.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_verdict(is_valid_o);
    end
    rx_count++;
    if (rx_count % 256 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    if (hold_left == 0 && hold_asks != hold_taken) begin
      hold_taken++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 9) < 7);
        2: out_ready_i <= ($urandom_range(0, 9) < 3);
        default: out_ready_i <= ((rx_count % 7) >= 2);
      endcase
    end
  end

  // Offers one request and waits until it is taken. The sender works in
  // bursts; valid drops only between bursts.
  task automatic send_char(input logic [CharW-1:0] c, input logic last,
                           input logic empty);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= c;
    is_last_i      <= last;
    empty_string_i <= empty;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(c, last, empty);
    burst_left--;
    sent++;
  endtask

  task automatic send_empty();
    send_char(CharW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  function automatic logic [CharW-1:0] digit_char(input logic [BaseW-1:0] b);
    int unsigned top;
    int unsigned v;
    top = (b > 36) ? 36 : b;
    v   = $urandom_range(0, top - 1);
    if (v < 10) begin
      return ilv_pkg::ChZero + CharW'(v);
    end
    return ($urandom_range(0, 1) ? ilv_pkg::ChLowA : ilv_pkg::ChUpA) + CharW'(v - 10);
  endfunction

  // Mostly well-formed literals for the current base; the rest are empty
  // strings, corrupted characters and strings abandoned by an empty request.
  task automatic send_random_string(input logic [BaseW-1:0] b);
    logic [CharW-1:0] txt[$];
    int unsigned      kind;
    int unsigned      len;
    bit               abandon;
    kind    = $urandom_range(0, 99);
    len     = $urandom_range(0, 6);
    abandon = (kind >= 18 && kind < 24);
    if (kind < 6) begin
      send_empty();
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      txt.push_back(ilv_pkg::ChMinus);
    end
    if (b == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          txt.push_back(ilv_pkg::ChZero);
          txt.push_back($urandom_range(0, 1) ? ilv_pkg::ChLowX : ilv_pkg::ChUpX);
          repeat (len) txt.push_back(digit_char(ilv_pkg::BaseHex));
        end
        1: begin
          txt.push_back(ilv_pkg::ChZero);
          txt.push_back($urandom_range(0, 1) ? ilv_pkg::ChLowB : ilv_pkg::ChUpB);
          repeat (len) txt.push_back(digit_char(ilv_pkg::BaseBin));
        end
        2: begin
          txt.push_back(ilv_pkg::ChZero);
          repeat (len) txt.push_back(digit_char(ilv_pkg::BaseOct));
        end
        default: begin
          txt.push_back(ilv_pkg::ChZero + CharW'($urandom_range(1, 9)));
          repeat (len) txt.push_back(digit_char(ilv_pkg::BaseDec));
        end
      endcase
    end else begin
      repeat (len + 1) txt.push_back(digit_char(b));
    end
    if (kind >= 6 && kind < 18) begin
      txt[$urandom_range(0, txt.size() - 1)] = CharW'($urandom_range(0, 255));
    end
    for (int i = 0; i < txt.size(); i++) begin
      send_char(txt[i], !abandon && i == txt.size() - 1, 1'b0);
    end
    if (abandon) begin
      send_empty();
    end
  endtask

  // Drops valid, lets every verdict drain, then lets the pipeline settle.
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [BaseW-1:0] b);
    number_base_we_i <= 1'b1;
    number_base_i    <= b;
    @(posedge clk_i);
    number_base_we_i <= 1'b0;
    sb.set_base(b);
  endtask

  // A burst of one-character strings while the receiver holds off, so the
  // block backs up and stalls its input.
  task automatic squeeze(input logic [BaseW-1:0] b);
    bit keep;
    keep      = steady;
    steady    = 1'b1;
    hold_asks <= hold_asks + 1;
    repeat (40) begin
      send_char((b == 0) ? ilv_pkg::ChZero + CharW'($urandom_range(0, 9))
                         : digit_char(b),
                1'b1, 1'b0);
    end
    steady = keep;
  endtask

  initial begin
    logic [BaseW-1:0] bases[14];
    int unsigned      quota;
    bases = '{6'd2, 6'd8, 6'd16, 6'd10, 6'd1, 6'd63, 6'd37, 6'd0, 6'd3, 6'd0,
              6'd36, 6'd0, 6'd0, 6'd0};
    bases[12] = BaseW'($urandom_range(2, 36));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset base of 10: empty string, lone sign, signed digit, top byte code.
    send_empty();
    send_text("-");
    send_text("-9");
    send_char(8'hff, 1'b1, 1'b0);
    finish_phase();

    // Inferred base: lone zero, bare 0x prefix, 0X and 0B prefixes with a digit,
    // a non-octal digit after zero, signed decimal, and an abandoned string.
    write_base('0);
    send_text("0");
    send_text("0x");
    send_text("0Xf");
    send_text("0B1");
    send_text("08");
    send_text("-7");
    send_char("5", 1'b0, 1'b0);
    send_empty();
    finish_phase();

    write_base(6'd36);
    send_text("Zz");
    finish_phase();

    foreach (bases[p]) begin
      write_base(bases[p]);
      steady = (p % 5 == 3);
      quota  = sent + 100;
      if (p % 4 == 1) begin
        squeeze(bases[p]);
      end
      while (sent < quota) begin
        send_random_string(bases[p]);
      end
      finish_phase();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ilv_pkg.sv
hdl/ilv_step.sv
hdl/integer_literal_validator.sv
tb/sv/testbench.sv
